/* hw/rtl/fit4_pkg.sv */
// shared constants and types of the 4x4 forward integer transform
`timescale 1ns / 1ps

package fit4_pkg;

  localparam int SAMPLE_BITS_DEF = 9;
  localparam int COEF_BITS       = 15;
  localparam int BLK_N           = 4;
  localparam int ROW_IDX_W       = 2;
  localparam int OUT_TDATA_W     = ((ROW_IDX_W + BLK_N * COEF_BITS + 7) / 8) * 8;

  localparam logic [ROW_IDX_W-1:0] LAST_ROW = 2'd3;

  typedef logic signed [COEF_BITS-1:0] coef_t;

  typedef struct packed {
    logic busy;
    logic ending;
  } obuf_stat_t;

endpackage

/* hw/rtl/fit4_butterfly.sv */
// one 4-point forward core transform lane (butterfly)
`timescale 1ns / 1ps

module fit4_butterfly #(
  parameter int IN_W = 9
) (
  input  logic signed [IN_W-1:0] a0,
  input  logic signed [IN_W-1:0] a1,
  input  logic signed [IN_W-1:0] a2,
  input  logic signed [IN_W-1:0] a3,
  output logic signed [IN_W+2:0] y0,
  output logic signed [IN_W+2:0] y1,
  output logic signed [IN_W+2:0] y2,
  output logic signed [IN_W+2:0] y3
);

  logic signed [IN_W:0]   s03;
  logic signed [IN_W:0]   s12;
  logic signed [IN_W:0]   d03;
  logic signed [IN_W:0]   d12;
  logic signed [IN_W+2:0] s03_x;
  logic signed [IN_W+2:0] s12_x;
  logic signed [IN_W+2:0] d03_x;
  logic signed [IN_W+2:0] d12_x;

  assign s03 = (IN_W+1)'(a0) + (IN_W+1)'(a3);
  assign s12 = (IN_W+1)'(a1) + (IN_W+1)'(a2);
  assign d03 = (IN_W+1)'(a0) - (IN_W+1)'(a3);
  assign d12 = (IN_W+1)'(a1) - (IN_W+1)'(a2);

  assign s03_x = (IN_W+3)'(s03);
  assign s12_x = (IN_W+3)'(s12);
  assign d03_x = (IN_W+3)'(d03);
  assign d12_x = (IN_W+3)'(d12);

  assign y0 = s03_x + s12_x;
  assign y1 = (d03_x <<< 1) + d12_x;
  assign y2 = s03_x - s12_x;
  assign y3 = d03_x - (d12_x <<< 1);

endmodule

/* hw/rtl/fit4_outbuf.sv */
// coefficient block buffer: clips lane results and drains them row by row
`timescale 1ns / 1ps

module fit4_outbuf #(
  parameter int IN_W = 15
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 load,
  input  logic signed [IN_W-1:0]               coef_in [4][4],
  output fit4_pkg::obuf_stat_t                 stat,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // row_index, coef_col0, coef_col1, coef_col2, coef_col3, zero pad
  output logic [fit4_pkg::OUT_TDATA_W-1:0]     m_tdata,
  // last_row
  output logic                                 m_tlast
);

  import fit4_pkg::*;

  localparam int EXT_W = (IN_W > COEF_BITS) ? IN_W : COEF_BITS;
  localparam logic signed [EXT_W-1:0] SAT_HI = EXT_W'((64'd1 << (COEF_BITS - 1)) - 64'd1);
  localparam logic signed [EXT_W-1:0] SAT_LO = ~SAT_HI;

  coef_t                  rows [BLK_N][BLK_N];
  coef_t                  sat  [BLK_N][BLK_N];
  logic                   valid;
  logic [ROW_IDX_W-1:0]   ptr;
  logic                   pop;

  always_comb begin
    logic signed [EXT_W-1:0] ext;
    for (int r = 0; r < BLK_N; r++) begin
      for (int c = 0; c < BLK_N; c++) begin
        ext = EXT_W'(coef_in[r][c]);
        if (ext > SAT_HI) begin
          ext = SAT_HI;
        end else if (ext < SAT_LO) begin
          ext = SAT_LO;
        end
        sat[r][c] = COEF_BITS'(ext);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rows <= sat;
    end
  end

  assign pop = valid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      ptr   <= '0;
    end else if (load) begin
      valid <= 1'b1;
      ptr   <= '0;
    end else if (pop) begin
      if (ptr == LAST_ROW) begin
        valid <= 1'b0;
      end
      ptr <= ptr + 1'b1;
    end
  end

  always_comb begin
    m_tdata = '0;
    m_tdata[ROW_IDX_W-1:0] = ptr;
    for (int c = 0; c < BLK_N; c++) begin
      m_tdata[ROW_IDX_W + c * COEF_BITS +: COEF_BITS] = rows[ptr][c];
    end
  end

  assign m_tvalid    = valid;
  assign m_tlast     = (ptr == LAST_ROW);
  assign stat.busy   = valid;
  assign stat.ending = pop && (ptr == LAST_ROW);

endmodule

/* hw/rtl/forward_integer_transform_4x4.sv */
// Takes a 4x4 residual block one row per transaction and returns the exact integer core
// transform C*X*C' as four coefficient rows, row_index 0..3, the last one with tlast set.
// Each incoming row goes through a row lane at once and is kept in a three-row store; the
// fourth row feeds four column lanes in the same cycle and the whole block lands in the
// output buffer, whose first row is offered on the next cycle. Rows are taken one per
// cycle and given out one per cycle while m_tready is high; the fourth row of a block waits
// only while the output buffer still holds rows of the previous block other than its
// last one being taken in that cycle. Coefficients beyond 15 bits are clipped.
`timescale 1ns / 1ps

module forward_integer_transform_4x4 #(
  parameter int SAMPLE_BITS = fit4_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // res_col0, res_col1, res_col2, res_col3, zero pad
  input  logic [((4 * SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // row_index, coef_col0, coef_col1, coef_col2, coef_col3, zero pad
  output logic [fit4_pkg::OUT_TDATA_W-1:0]      m_tdata,
  // last_row
  output logic                                  m_tlast
);

  import fit4_pkg::*;

  localparam int ROW_W = SAMPLE_BITS + 3;
  localparam int COL_W = SAMPLE_BITS + 6;

  logic signed [SAMPLE_BITS-1:0] res       [BLK_N];
  logic signed [ROW_W-1:0]       row_t     [BLK_N];
  logic signed [ROW_W-1:0]       row_store [BLK_N-1][BLK_N];
  logic signed [COL_W-1:0]       col_y     [BLK_N][BLK_N];
  logic [ROW_IDX_W-1:0]          rows_loaded;
  logic                          in_acc;
  logic                          block_done;
  obuf_stat_t                    stat;

  for (genvar i = 0; i < BLK_N; i++) begin : g_unpack
    assign res[i] = s_tdata[i * SAMPLE_BITS +: SAMPLE_BITS];
  end

  // row lane
  fit4_butterfly #(.IN_W(SAMPLE_BITS)) u_row (
    .a0 (res[0]),
    .a1 (res[1]),
    .a2 (res[2]),
    .a3 (res[3]),
    .y0 (row_t[0]),
    .y1 (row_t[1]),
    .y2 (row_t[2]),
    .y3 (row_t[3])
  );

  assign in_acc     = s_tvalid && s_tready;
  assign block_done = in_acc && (rows_loaded == LAST_ROW);
  assign s_tready   = (rows_loaded != LAST_ROW) || !stat.busy || stat.ending;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_loaded <= '0;
    end else if (in_acc) begin
      rows_loaded <= rows_loaded + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (rows_loaded != LAST_ROW)) begin
      row_store[rows_loaded] <= row_t;
    end
  end

  // column lanes, fourth row taken straight from the row lane
  for (genvar j = 0; j < BLK_N; j++) begin : g_col
    fit4_butterfly #(.IN_W(ROW_W)) u_col (
      .a0 (row_store[0][j]),
      .a1 (row_store[1][j]),
      .a2 (row_store[2][j]),
      .a3 (row_t[j]),
      .y0 (col_y[0][j]),
      .y1 (col_y[1][j]),
      .y2 (col_y[2][j]),
      .y3 (col_y[3][j])
    );
  end

  fit4_outbuf #(.IN_W(COL_W)) u_obuf (
    .clk      (clk),
    .rst      (rst),
    .load     (block_done),
    .coef_in  (col_y),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    block_done |-> (!m_tvalid || (m_tready && m_tlast)))
    else $error("block loaded over undelivered rows");

  a_row_step: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=>
      (m_tvalid && (m_tdata[ROW_IDX_W-1:0] == $past(m_tdata[ROW_IDX_W-1:0]) + 2'd1)))
    else $error("coefficient rows out of order");

  a_block_end: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid || $past(block_done)))
    else $error("output still valid after last row");

  a_load_start: assert property (@(posedge clk) disable iff (rst)
    block_done |=> (m_tvalid && (m_tdata[ROW_IDX_W-1:0] == 2'd0)))
    else $error("new block does not start at row zero");

endmodule
